// ----- sv/aaf_pkg.sv -----
// Shared types and constants of the annular azimuthal force pipeline.
package aaf_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 33;

    localparam logic [1:0] REG_INNER = 2'd0;
    localparam logic [1:0] REG_OUTER = 2'd1;
    localparam logic [1:0] REG_CONST = 2'd2;

    typedef struct packed {
        logic        [11:0] particle_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic        [11:0] out_index;
        logic signed [47:0] force_x_delta;
        logic signed [47:0] force_y_delta;
        logic               in_band;
    } t_out_word;

endpackage

// ----- sv/aaf_isqrt.sv -----
// Pipelined integer square root: one result bit per stage.
module aaf_isqrt (
    input  logic        i_clk,
    input  logic [63:0] i_s,
    output logic [31:0] o_root
);
    import aaf_pkg::*;

    logic [33:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];
    logic [63:0] r_s    [SQRT_STAGES];
    logic [33:0] n_rem  [SQRT_STAGES];
    logic [31:0] n_root [SQRT_STAGES];
    logic [63:0] n_s    [SQRT_STAGES];

    // Try the next root bit against the remainder and the next bit pair
    always_comb begin
        logic [35:0] cur;
        logic [35:0] trial;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] s_in;
        for (int j = 0; j < SQRT_STAGES; j++) begin
            rem_in  = (j == 0) ? 34'd0 : r_rem[(j == 0) ? 0 : j - 1];
            root_in = (j == 0) ? 32'd0 : r_root[(j == 0) ? 0 : j - 1];
            s_in    = (j == 0) ? i_s : r_s[(j == 0) ? 0 : j - 1];
            cur     = {rem_in, s_in[63:62]};
            trial   = {2'b00, root_in, 2'b01};
            n_s[j]  = {s_in[61:0], 2'b00};
            if (cur >= trial) begin
                n_rem[j]  = 34'(cur - trial);
                n_root[j] = {root_in[30:0], 1'b1};
            end else begin
                n_rem[j]  = cur[33:0];
                n_root[j] = {root_in[30:0], 1'b0};
            end
        end
    end

    // Advance every stage each cycle
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SQRT_STAGES; j++) begin
            r_rem[j]  <= n_rem[j];
            r_root[j] <= n_root[j];
            r_s[j]    <= n_s[j];
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// ----- sv/aaf_divide.sv -----
// Pipelined restoring divider, 64 by 32 bits, quotient below 2^33.
module aaf_divide (
    input  logic        i_clk,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [32:0] o_quot
);
    import aaf_pkg::*;

    logic [31:0] r_rem  [DIV_STAGES];
    logic [32:0] r_quot [DIV_STAGES];
    logic [32:0] r_low  [DIV_STAGES];
    logic [31:0] r_den  [DIV_STAGES];
    logic [31:0] n_rem  [DIV_STAGES];
    logic [32:0] n_quot [DIV_STAGES];
    logic [32:0] n_low  [DIV_STAGES];

    // Shift in one numerator bit and subtract where it fits
    always_comb begin
        logic [32:0] t;
        logic [31:0] rem_in;
        logic [32:0] quot_in;
        logic [32:0] low_in;
        logic [31:0] den_in;
        for (int j = 0; j < DIV_STAGES; j++) begin
            rem_in  = (j == 0) ? {1'b0, i_num[63:33]} : r_rem[(j == 0) ? 0 : j - 1];
            quot_in = (j == 0) ? 33'd0 : r_quot[(j == 0) ? 0 : j - 1];
            low_in  = (j == 0) ? i_num[32:0] : r_low[(j == 0) ? 0 : j - 1];
            den_in  = (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
            t        = {rem_in, low_in[32]};
            n_low[j] = {low_in[31:0], 1'b0};
            if (t >= {1'b0, den_in}) begin
                n_rem[j]  = 32'(t - {1'b0, den_in});
                n_quot[j] = {quot_in[31:0], 1'b1};
            end else begin
                n_rem[j]  = t[31:0];
                n_quot[j] = {quot_in[31:0], 1'b0};
            end
        end
    end

    // Advance every stage each cycle
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            r_rem[j]  <= n_rem[j];
            r_quot[j] <= n_quot[j];
            r_low[j]  <= n_low[j];
            r_den[j]  <= (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule

// ----- sv/annular_azimuthal_force.sv -----
// Top level: annular azimuthal force increment pipeline.
//
//   channel   signals                                  direction
//   item      start, busy, i_item                      in
//   result    o_result_strobe, o_result                out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data          in
//
// One word enters per cycle. The stages are: three front stages (magnitudes,
// products, square sum with band test), a 32-stage square root (one root bit per
// stage), a rounding stage, a 33-stage divider and the output register.
// busy stays low; the receiver cannot stall, so the pipeline never holds.
// Synchronous active-low reset clears the valid line and the configuration registers.
module annular_azimuthal_force #(
    parameter int MAX_PARTICLES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  aaf_pkg::t_in_word i_item,
    output logic              o_result_strobe,
    output aaf_pkg::t_out_word o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import aaf_pkg::*;

    localparam int LAT = 3 + SQRT_STAGES + 1 + DIV_STAGES;

    typedef struct packed {
        logic [11:0] idx;
        logic        band;
        logic        neg_x;
        logic        neg_y;
        logic [63:0] pcx;
        logic [63:0] pcy;
    } t_side;

    // configuration
    logic [30:0]        r_inner, r_outer;
    logic signed [31:0] r_const;
    logic [63:0]        r_in2, r_out2;
    logic [31:0]        w_abs_c;

    // front stages
    logic [LAT:0]       r_valid;
    logic [11:0]        r_idx0;
    logic [31:0]        r_ax, r_ay;
    logic               r_nx0, r_ny0;
    logic [11:0]        r_idx1;
    logic [63:0]        r_sx, r_sy, r_pcx1, r_pcy1;
    logic               r_nx1, r_ny1;
    logic [63:0]        r_s;
    t_side              r_side2;
    t_side              r_sq_line [SQRT_STAGES];
    t_side              r_rnd;
    t_side              r_div_line [DIV_STAGES];
    logic [63:0]        r_numx, r_numy;
    logic [31:0]        r_den;
    logic [31:0]        w_root;
    logic [32:0]        w_qx, w_qy;
    t_side              w_last;
    logic               w_band;
    t_out_word          r_result;

    assign busy = 1'b0;

    // Take register writes; ignore indexes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= '0;
            r_outer <= '0;
            r_const <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INNER: r_inner <= i_cfg_data[30:0];
                REG_OUTER: r_outer <= i_cfg_data[30:0];
                REG_CONST: r_const <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_abs_c = r_const[31] ? 32'(-r_const) : 32'(r_const);

    // Hold band squares; the user must let config settle while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_in2  <= 64'(r_inner) * 64'(r_inner);
        r_out2 <= 64'(r_outer) * 64'(r_outer);
    end

    // Advance the valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LAT-1:0], start};
        end
    end

    // Stage 0: magnitudes and signs
    always_ff @(posedge i_clk) begin
        r_idx0 <= i_item.particle_index;
        r_ax   <= i_item.pos_x[31] ? 32'(-i_item.pos_x) : 32'(i_item.pos_x);
        r_ay   <= i_item.pos_y[31] ? 32'(-i_item.pos_y) : 32'(i_item.pos_y);
        r_nx0  <= ~(r_const[31] ^ i_item.pos_y[31]);
        r_ny0  <= r_const[31] ^ i_item.pos_x[31];
    end

    // Stage 1: squares and force products
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_idx0;
        r_sx   <= 64'(r_ax) * 64'(r_ax);
        r_sy   <= 64'(r_ay) * 64'(r_ay);
        r_pcx1 <= 64'(w_abs_c) * 64'(r_ay);
        r_pcy1 <= 64'(w_abs_c) * 64'(r_ax);
        r_nx1  <= r_nx0;
        r_ny1  <= r_ny0;
    end

    // Stage 2: radius squared and band test
    always_ff @(posedge i_clk) begin
        logic [63:0] s;
        s             = r_sx + r_sy;
        r_s           <= s;
        r_side2.idx   <= r_idx1;
        r_side2.band  <= (s > r_in2) && (s < r_out2) &&
                         ({20'd0, r_idx1} < 32'(MAX_PARTICLES));
        r_side2.neg_x <= r_nx1;
        r_side2.neg_y <= r_ny1;
        r_side2.pcx   <= r_pcx1;
        r_side2.pcy   <= r_pcy1;
    end

    aaf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_s    (r_s),
        .o_root (w_root)
    );

    // Carry side data alongside the root stages
    always_ff @(posedge i_clk) begin
        r_sq_line[0] <= r_side2;
        for (int j = 1; j < SQRT_STAGES; j++) r_sq_line[j] <= r_sq_line[j-1];
    end

    // Add half the radius for round-to-nearest; drop zero radius
    always_ff @(posedge i_clk) begin
        t_side rnd;
        rnd       = r_sq_line[SQRT_STAGES-1];
        rnd.band  = rnd.band && (w_root != 32'd0);
        r_numx    <= r_sq_line[SQRT_STAGES-1].pcx + 64'(w_root[31:1]);
        r_numy    <= r_sq_line[SQRT_STAGES-1].pcy + 64'(w_root[31:1]);
        r_den     <= w_root;
        r_rnd     <= rnd;
    end

    aaf_divide u_div_x (
        .i_clk  (i_clk),
        .i_num  (r_numx),
        .i_den  (r_den),
        .o_quot (w_qx)
    );

    aaf_divide u_div_y (
        .i_clk  (i_clk),
        .i_num  (r_numy),
        .i_den  (r_den),
        .o_quot (w_qy)
    );

    // Carry side data alongside the divider stages
    always_ff @(posedge i_clk) begin
        r_div_line[0] <= r_rnd;
        for (int j = 1; j < DIV_STAGES; j++) r_div_line[j] <= r_div_line[j-1];
    end

    assign w_last = r_div_line[DIV_STAGES-1];
    assign w_band = w_last.band;

    // Apply signs, zero out-of-band words, register the result
    always_ff @(posedge i_clk) begin
        r_result.out_index     <= w_last.idx;
        r_result.in_band       <= w_band;
        r_result.force_x_delta <= !w_band ? 48'sd0 :
                                  w_last.neg_x ? -$signed(48'(w_qx)) : $signed(48'(w_qx));
        r_result.force_y_delta <= !w_band ? 48'sd0 :
                                  w_last.neg_y ? -$signed(48'(w_qy)) : $signed(48'(w_qy));
    end

    assign o_result_strobe = r_valid[LAT];
    assign o_result        = r_result;

endmodule

// ----- tb/annular_azimuthal_force_tb.sv -----
// Testbench for the annular azimuthal force pipeline: directed and random words.
module annular_azimuthal_force_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aaf_pkg::*;

    localparam int LATENCY = 71;
    localparam int N_PART  = 4096;
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in_word i_item;
    logic o_result_strobe;
    t_out_word o_result;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    logic [30:0] band_inner;
    logic [30:0] band_outer;
    logic signed [31:0] spin_const;
    t_out_word force_q[$];
    int err_count;

    annular_azimuthal_force #(.MAX_PARTICLES(N_PART)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_strobe(o_result_strobe), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Round |a*b|/r to nearest, ties away from zero, then apply sign.
    function automatic logic signed [47:0] tangential(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic [63:0] r);
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] q;
        mag_a = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
        mag_b = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
        q = (mag_a * mag_b + (r >> 1)) / r;
        return (a[31] != b[31]) ? -48'(q) : 48'(q);
    endfunction

    // Bitwise floor square root.
    function automatic logic [63:0] floor_root(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= s) root = trial;
        end
        return root;
    endfunction

    function automatic t_out_word predict_force(input t_in_word w);
        t_out_word res;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] s;
        logic [63:0] r;
        ax = w.pos_x[31] ? 64'(-64'(signed'(w.pos_x))) : 64'(w.pos_x);
        ay = w.pos_y[31] ? 64'(-64'(signed'(w.pos_y))) : 64'(w.pos_y);
        s = ax * ax + ay * ay;
        res = '0;
        res.out_index = w.particle_index;
        if (s > 64'(band_inner) * 64'(band_inner) && s < 64'(band_outer) * 64'(band_outer)
            && int'(w.particle_index) < N_PART) begin
            r = floor_root(s);
            if (r != 0) begin
                res.in_band = 1'b1;
                res.force_x_delta = -tangential(spin_const, w.pos_y, r);
                res.force_y_delta = tangential(spin_const, w.pos_x, r);
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
        err_count++;
    endtask

    // Check each result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word exp;
        if (i_rst_n && o_result_strobe) begin
            if (force_q.size() == 0) begin
                report("unexpected word", 64'(o_result.out_index), 64'd0);
            end else begin
                exp = force_q.pop_front();
                if (o_result.out_index !== exp.out_index)
                    report("out_index", 64'(o_result.out_index), 64'(exp.out_index));
                if (o_result.force_x_delta !== exp.force_x_delta)
                    report("force_x_delta", 64'(o_result.force_x_delta),
                           64'(exp.force_x_delta));
                if (o_result.force_y_delta !== exp.force_y_delta)
                    report("force_y_delta", 64'(o_result.force_y_delta),
                           64'(exp.force_y_delta));
                if (o_result.in_band !== exp.in_band)
                    report("in_band", 64'(o_result.in_band), 64'(exp.in_band));
            end
        end
    end

    // Send one word; hold start until accepted.
    task automatic send_word(input t_in_word w);
        start <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        force_q.push_back(predict_force(w));
    endtask

    task automatic pause_idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait for the pipe to drain.
    task automatic drain;
        start <= 1'b0;
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_INNER: band_inner = data[30:0];
            REG_OUTER: band_outer = data[30:0];
            REG_CONST: spin_const = data;
            default: ;
        endcase
    endtask

    task automatic set_band(input logic [31:0] inner, input logic [31:0] outer,
                            input logic [31:0] c);
        drain();
        write_reg(REG_INNER, inner);
        write_reg(REG_OUTER, outer);
        write_reg(REG_CONST, c);
    endtask

    function automatic t_in_word mk(input logic [11:0] idx, input logic [31:0] x,
                                    input logic [31:0] y);
        t_in_word w;
        w.particle_index = idx;
        w.pos_x = x;
        w.pos_y = y;
        return w;
    endfunction

    // Extremes, radius edges, empty band, highest index, unused register.
    task automatic test_directed;
        set_band(32'h0100_0000, 32'h0400_0000, 32'h7FFF_FFFF);
        send_word(mk(12'd0, 32'h0200_0000, 32'h0));
        send_word(mk(12'hFFF, 32'h0200_0000, 32'h0200_0000));
        send_word(mk(12'd5, 32'h0100_0000, 32'h0));
        send_word(mk(12'd6, 32'h0, 32'hFC00_0000));
        send_word(mk(12'd7, 32'hFE00_0000, 32'hFF00_0000));
        send_word(mk(12'd8, 32'h8000_0000, 32'h8000_0000));
        send_word(mk(12'd9, 32'h7FFF_FFFF, 32'h0));
        send_word(mk(12'd10, 32'h0, 32'h0));
        set_band(32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(mk(12'd1, 32'h0, 32'h0));
        send_word(mk(12'd2, 32'h0000_0001, 32'h0));
        send_word(mk(12'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(mk(12'd4, 32'h7FFF_FFFF, 32'h8000_0000));
        send_word(mk(12'd11, 32'h8000_0000, 32'h0000_0003));
        send_word(mk(12'hABC, 32'h1234_5678, 32'hEDCB_A987));
        set_band(32'h0400_0000, 32'h0100_0000, 32'h1234_5678);
        send_word(mk(12'd12, 32'h0200_0000, 32'h0));
        drain();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_word(mk(12'd13, 32'h0200_0000, 32'h0));
    endtask

    function automatic logic [31:0] rand_pos(input int scale);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 2 * scale)) - scale);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 2 * 16)) - 16);
        endcase
    endfunction

    // Random words in bursts, some scaled to the band, under several settings.
    task automatic test_random(input int n_words);
        int sent;
        int burst;
        int scale;
        sent = 0;
        while (sent < n_words) begin
            if (sent % 160 == 0) begin
                case ((sent / 160) % 4)
                    0: set_band(32'h0, 32'h7FFF_FFFF, $urandom);
                    1: set_band($urandom_range(0, 32'h0200_0000),
                                32'h0200_0000 + $urandom_range(0, 32'h0400_0000), $urandom);
                    2: set_band($urandom_range(0, 64), $urandom_range(64, 4096), $urandom);
                    default: set_band($urandom, $urandom, $urandom);
                endcase
            end
            scale = (band_outer > 31'd8) ? int'(band_outer) : 1024;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < n_words; k++) begin
                send_word(mk(12'($urandom_range(0, 4095)), rand_pos(scale), rand_pos(scale)));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_idle($urandom_range(1, 6));
            if (sent % 300 < 20) drain();
        end
    endtask

    initial begin : watchdog
        #200000;
        $display("FAIL");
        $finish;
    end

    initial begin
        err_count = 0;
        band_inner = '0;
        band_outer = '0;
        spin_const = '0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(950);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_count == 0 && force_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
sv/aaf_pkg.sv
sv/aaf_isqrt.sv
sv/aaf_divide.sv
sv/annular_azimuthal_force.sv
tb/annular_azimuthal_force_tb.sv
